[hdl/peer_table_with_aging_unit_assert.svh]
// Assertion helpers shared by the peer table modules.
// Both sample on aclk and stay quiet while aresetn is low.
`ifndef PEER_TABLE_WITH_AGING_UNIT_ASSERT_SVH
`define PEER_TABLE_WITH_AGING_UNIT_ASSERT_SVH

// Property that must hold at every edge
`define PTA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next
`define PTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pta_pkg.sv]
package pta_pkg;

    // Table geometry
    localparam int MAX_PEERS         = 16;
    localparam int FINGERPRINT_BYTES = 8;
    localparam int IDX_W             = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CNT_W             = $clog2(MAX_PEERS + 1);

    // Fixed field widths
    localparam int FP_W        = 64;
    localparam int TIME_W      = 32;
    localparam int VER_W       = 8;
    localparam int SIG_W       = 8;
    localparam int CTR_W       = 16;
    localparam int ENTRY_IDX_W = 4;
    localparam int TOTAL_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // Only the low fingerprint bytes take part in matching
    localparam logic [FP_W-1:0] KEY_MASK = (FINGERPRINT_BYTES >= 8) ? {FP_W{1'b1}} :
        FP_W'((65'd1 << (8 * FINGERPRINT_BYTES)) - 65'd1);

    localparam logic signed [SIG_W-1:0] SIGNAL_FLOOR = -8'sd127;

    // Configuration reset values
    localparam logic [VER_W-1:0]  PROTOCOL_VERSION_RST = 8'd1;
    localparam logic [FP_W-1:0]   OWN_FINGERPRINT_RST  = '0;
    localparam logic [TIME_W-1:0] TIMEOUT_MS_RST       = 32'd30000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROTOCOL_VERSION = 2'd0,
        CFG_OWN_FINGERPRINT  = 2'd1,
        CFG_TIMEOUT_MS       = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ACT_SHORT       = 3'd0,
        ACT_BAD_VERSION = 3'd1,
        ACT_SELF        = 3'd2,
        ACT_UPDATED     = 3'd3,
        ACT_INSERTED    = 3'd4,
        ACT_FULL        = 3'd5,
        ACT_CHECK_DONE  = 3'd6
    } act_t;

    typedef struct packed {
        logic                    op;
        logic [TIME_W-1:0]       now_ms;
        logic                    payload_short;
        logic [VER_W-1:0]        adv_version;
        logic [FP_W-1:0]         fingerprint;
        logic [CTR_W-1:0]        run_count;
        logic [CTR_W-1:0]        total_count;
        logic signed [SIG_W-1:0] signal_strength;
    } in_req_t;

    typedef struct packed {
        act_t                    action;
        logic [ENTRY_IDX_W-1:0]  entry_index;
        logic [TOTAL_W-1:0]      peer_total;
        logic signed [SIG_W-1:0] closest_signal;
        logic [TOTAL_W-1:0]      newly_gone;
    } out_rsp_t;

    // Request token walking down the cell chain
    typedef struct packed {
        logic                    vld;
        logic                    is_check;
        logic                    is_live;   // advert that still needs the table
        act_t                    act;
        logic                    found;
        logic [IDX_W-1:0]        index;
        logic [FP_W-1:0]         key;
        logic [TIME_W-1:0]       now;
        logic signed [SIG_W-1:0] signal;
        logic [CTR_W-1:0]        run;
        logic [CTR_W-1:0]        total;
        logic [CNT_W-1:0]        cnt;
        logic signed [SIG_W-1:0] best;
        logic [CNT_W-1:0]        gone_cnt;
    } tok_t;

endpackage

[hdl/pta_front.sv]
module pta_front
    import pta_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv_en,
    input  logic              s_valid,
    input  in_req_t           s_req,
    input  logic [VER_W-1:0]  protocol_version,
    input  logic [FP_W-1:0]   own_fingerprint,
    output tok_t              tok_out
);

    tok_t tok_reg;
    tok_t tok_next;

    // Classify the request: checks, rejects and adverts for the table
    always_comb begin
        tok_next          = '0;
        tok_next.vld      = s_valid;
        tok_next.key      = s_req.fingerprint & KEY_MASK;
        tok_next.now      = s_req.now_ms;
        tok_next.signal   = s_req.signal_strength;
        tok_next.run      = s_req.run_count;
        tok_next.total    = s_req.total_count;
        tok_next.best     = SIGNAL_FLOOR;
        priority if (s_req.op) begin
            tok_next.is_check = 1'b1;
            tok_next.act      = ACT_CHECK_DONE;
        end else if (s_req.payload_short) begin
            tok_next.act = ACT_SHORT;
        end else if (s_req.adv_version != protocol_version) begin
            tok_next.act = ACT_BAD_VERSION;
        end else if ((s_req.fingerprint & KEY_MASK) == (own_fingerprint & KEY_MASK)) begin
            tok_next.act = ACT_SELF;
        end else begin
            // stays FULL unless a cell matches or takes it
            tok_next.is_live = 1'b1;
            tok_next.act     = ACT_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else if (adv_en) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[hdl/pta_cell.sv]
module pta_cell
    import pta_pkg::*;
`include "peer_table_with_aging_unit_assert.svh"
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv_en,
    input  logic [IDX_W-1:0]  cell_id,
    input  logic [TIME_W-1:0] timeout_ms,
    input  logic              prev_valid,
    input  tok_t              tok_in,
    output tok_t              tok_out,
    output logic              valid_out
);

    // Entry held by this cell
    logic                    v_reg, v_next;
    logic [FP_W-1:0]         fp_reg, fp_next;
    logic signed [SIG_W-1:0] sig_reg, sig_next;
    logic [TIME_W-1:0]       seen_reg, seen_next;
    logic                    gone_reg, gone_next;
    logic [CTR_W-1:0]        run_reg, run_next;
    logic [CTR_W-1:0]        total_reg, total_next;
    tok_t                    tok_reg, tok_next;

    logic              hit;
    logic              ins;
    logic              expire;
    logic [TIME_W-1:0] age;

    // Match, append and expiry decisions
    assign hit    = tok_in.vld && tok_in.is_live && !tok_in.found && v_reg
                    && (fp_reg == tok_in.key);
    assign ins    = tok_in.vld && tok_in.is_live && !tok_in.found && !v_reg;
    assign age    = tok_in.now - seen_reg;
    assign expire = tok_in.vld && tok_in.is_check && v_reg && !gone_reg
                    && (age > timeout_ms);

    // Entry update
    always_comb begin
        v_next     = v_reg | ins;
        fp_next    = ins ? tok_in.key : fp_reg;
        sig_next   = sig_reg;
        seen_next  = seen_reg;
        gone_next  = gone_reg | expire;
        run_next   = run_reg;
        total_next = total_reg;
        if (hit || ins) begin
            sig_next   = tok_in.signal;
            seen_next  = tok_in.now;
            gone_next  = 1'b0;
            run_next   = tok_in.run;
            total_next = tok_in.total;
        end
    end

    // Token update: outcome, running count and strongest live signal
    always_comb begin
        tok_next = tok_in;
        if (hit || ins) begin
            tok_next.found = 1'b1;
            tok_next.index = cell_id;
            tok_next.act   = hit ? ACT_UPDATED : ACT_INSERTED;
        end
        tok_next.cnt      = tok_in.cnt + CNT_W'(v_next);
        tok_next.gone_cnt = tok_in.gone_cnt + CNT_W'(expire);
        if (v_next && !gone_next && (sig_next > tok_in.best)) begin
            tok_next.best = sig_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= 1'b0;
            tok_reg.vld <= 1'b0;
        end else if (adv_en) begin
            v_reg   <= v_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_en) begin
            fp_reg    <= fp_next;
            sig_reg   <= sig_next;
            seen_reg  <= seen_next;
            gone_reg  <= gone_next;
            run_reg   <= run_next;
            total_reg <= total_next;
        end
    end

    assign tok_out   = tok_reg;
    assign valid_out = v_reg;

    `PTA_ASSERT_NEXT(a_entry_kept, v_reg, v_reg, "peer entry was dropped")
    `PTA_ASSERT_ALWAYS(a_entries_packed, prev_valid || !v_reg,
        "valid entry behind an empty one")
    `PTA_ASSERT_NEXT(a_found_kept, adv_en && tok_in.vld && tok_in.found, tok_reg.found,
        "match flag lost in the chain")

endmodule

[hdl/peer_table_with_aging_unit.sv]
// Peer table with aging.
// Requests enter on s_valid/s_ready with payload s_req: op 0 is an advert
// (looked up by fingerprint, refreshed or appended), op 1 is a check that
// marks entries older than timeout_ms as gone. Every request gives exactly
// one response on m_valid/m_ready with payload m_rsp, in request order.
// Configuration: cfg_wr_en writes cfg_wr_data to register cfg_wr_index
// (0 protocol version, 1 own fingerprint, 2 timeout) at that clock edge.
// Each table entry lives in one cell of a chain of MAX_PEERS cells; a
// request steps one cell per cycle while the chain advances, behind a front
// classify stage, and then reaches the response register that drives m_valid;
// a new request can enter every cycle while s_ready is high.
// Reset (aresetn low, synchronous) empties the table, drops requests in
// flight and restores the configuration defaults.
// When m_ready is low with a response waiting, the whole chain holds and
// s_ready drops in the same cycle; nothing is lost or reordered.
module peer_table_with_aging_unit
    import pta_pkg::*;
`include "peer_table_with_aging_unit_assert.svh"
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_req_t               s_req,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_rsp_t              m_rsp
);

    logic [VER_W-1:0]  protocol_version_reg, protocol_version_next;
    logic [FP_W-1:0]   own_fingerprint_reg, own_fingerprint_next;
    logic [TIME_W-1:0] timeout_ms_reg, timeout_ms_next;
    logic              m_valid_reg, m_valid_next;
    out_rsp_t          m_rsp_reg, m_rsp_next;

    logic adv_en;
    tok_t tok_chain [MAX_PEERS+1];
    logic v_chain   [MAX_PEERS+1];

    // Chain moves whenever the response slot is free or being drained
    assign adv_en  = !m_valid_reg || m_ready;
    assign s_ready = adv_en;

    // Configuration registers
    always_comb begin
        protocol_version_next = protocol_version_reg;
        own_fingerprint_next  = own_fingerprint_reg;
        timeout_ms_next       = timeout_ms_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_wr_index))
                CFG_PROTOCOL_VERSION: protocol_version_next = cfg_wr_data[VER_W-1:0];
                CFG_OWN_FINGERPRINT:  own_fingerprint_next  = cfg_wr_data[FP_W-1:0];
                CFG_TIMEOUT_MS:       timeout_ms_next       = cfg_wr_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            protocol_version_reg <= PROTOCOL_VERSION_RST;
            own_fingerprint_reg  <= OWN_FINGERPRINT_RST;
            timeout_ms_reg       <= TIMEOUT_MS_RST;
        end else begin
            protocol_version_reg <= protocol_version_next;
            own_fingerprint_reg  <= own_fingerprint_next;
            timeout_ms_reg       <= timeout_ms_next;
        end
    end

    // Request classification
    pta_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .adv_en           (adv_en),
        .s_valid          (s_valid),
        .s_req            (s_req),
        .protocol_version (protocol_version_reg),
        .own_fingerprint  (own_fingerprint_reg),
        .tok_out          (tok_chain[0])
    );

    // Table cells, entry 0 first
    assign v_chain[0] = 1'b1;

    for (genvar i = 0; i < MAX_PEERS; i++) begin : g_cell
        pta_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv_en     (adv_en),
            .cell_id    (IDX_W'(i)),
            .timeout_ms (timeout_ms_reg),
            .prev_valid (v_chain[i]),
            .tok_in     (tok_chain[i]),
            .tok_out    (tok_chain[i+1]),
            .valid_out  (v_chain[i+1])
        );
    end

    // Response register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        if (adv_en) begin
            m_valid_next              = tok_chain[MAX_PEERS].vld;
            m_rsp_next.action         = tok_chain[MAX_PEERS].act;
            m_rsp_next.entry_index    = ENTRY_IDX_W'(tok_chain[MAX_PEERS].index);
            m_rsp_next.peer_total     = TOTAL_W'(tok_chain[MAX_PEERS].cnt);
            m_rsp_next.closest_signal = tok_chain[MAX_PEERS].best;
            m_rsp_next.newly_gone     = TOTAL_W'(tok_chain[MAX_PEERS].gone_cnt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_rsp_reg <= m_rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    `PTA_ASSERT_ALWAYS(a_check_no_index,
        !m_valid_reg || m_rsp_reg.action != ACT_CHECK_DONE || m_rsp_reg.entry_index == '0,
        "check response carries an entry index")
    `PTA_ASSERT_NEXT(a_rsp_held, m_valid_reg && !m_ready, m_valid_reg && $stable(m_rsp_reg),
        "response changed while stalled")
    `PTA_ASSERT_ALWAYS(a_total_range, !m_valid_reg || m_rsp_reg.peer_total <= MAX_PEERS,
        "peer total above table size")

endmodule

[sim/pta_table_checker.sv]
module pta_table_checker
    import pta_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_req_t               s_req,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_rsp_t              m_rsp,
    output int                    fail_count,
    output int                    open_requests
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 50;

    // Shadow of the configuration registers
    logic [VER_W-1:0]  accept_version;
    logic [FP_W-1:0]   self_key;
    logic [TIME_W-1:0] expire_ms;

    // Shadow peer table
    logic [CNT_W-1:0]        fill_level;
    logic [FP_W-1:0]         peer_key    [MAX_PEERS];
    logic signed [SIG_W-1:0] peer_signal [MAX_PEERS];
    logic [TIME_W-1:0]       peer_seen   [MAX_PEERS];
    logic                    peer_gone   [MAX_PEERS];
    logic [CTR_W-1:0]        peer_run    [MAX_PEERS];
    logic [CTR_W-1:0]        peer_runs_all [MAX_PEERS];

    out_rsp_t pending_results[$];
    int       results_seen;

    initial begin
        fail_count    = 0;
        open_requests = 0;
        results_seen  = 0;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("%0t ns: response %0d: %s", $time, results_seen, msg);
    endtask

    // Apply one request to the shadow table and work out its response
    function automatic out_rsp_t advance_table(input in_req_t r);
        out_rsp_t          rsp;
        logic [FP_W-1:0]   key;
        logic [TIME_W-1:0] age;
        int                slot;
        int                best;
        int                i;
        rsp  = '0;
        slot = -1;
        if (r.op) begin
            // aging sweep over live entries, wrapping time
            for (i = 0; i < int'(fill_level); i++) begin
                age = r.now_ms - peer_seen[i];
                if (!peer_gone[i] && age > expire_ms) begin
                    peer_gone[i]   = 1'b1;
                    rsp.newly_gone = rsp.newly_gone + 1'b1;
                end
            end
            rsp.action = ACT_CHECK_DONE;
        end else if (r.payload_short) begin
            rsp.action = ACT_SHORT;
        end else if (r.adv_version != accept_version) begin
            rsp.action = ACT_BAD_VERSION;
        end else begin
            key = r.fingerprint & KEY_MASK;
            if (key == (self_key & KEY_MASK)) begin
                rsp.action = ACT_SELF;
            end else begin
                for (i = 0; i < int'(fill_level); i++) begin
                    if (slot < 0 && peer_key[i] == key)
                        slot = i;
                end
                if (slot < 0 && fill_level >= MAX_PEERS) begin
                    rsp.action = ACT_FULL;
                end else begin
                    if (slot < 0) begin
                        slot           = int'(fill_level);
                        peer_key[slot] = key;
                        fill_level     = fill_level + 1'b1;
                        rsp.action     = ACT_INSERTED;
                    end else begin
                        rsp.action = ACT_UPDATED;
                    end
                    peer_signal[slot]   = r.signal_strength;
                    peer_seen[slot]     = r.now_ms;
                    peer_gone[slot]     = 1'b0;
                    peer_run[slot]      = r.run_count;
                    peer_runs_all[slot] = r.total_count;
                    rsp.entry_index     = ENTRY_IDX_W'(slot);
                end
            end
        end
        // strongest live signal; -128 never beats the floor
        best = SIGNAL_FLOOR;
        for (i = 0; i < int'(fill_level); i++) begin
            if (!peer_gone[i] && peer_signal[i] > best)
                best = peer_signal[i];
        end
        rsp.peer_total     = TOTAL_W'(fill_level);
        rsp.closest_signal = SIG_W'(best);
        return rsp;
    endfunction

    task automatic check_response(input out_rsp_t got);
        out_rsp_t want;
        if (pending_results.size() == 0) begin
            note_failure($sformatf("response with no request outstanding (action %0d)",
                got.action));
            return;
        end
        want = pending_results.pop_front();
        if (got.action !== want.action)
            note_failure($sformatf("action %0d, expected %0d", got.action, want.action));
        if (got.entry_index !== want.entry_index)
            note_failure($sformatf("entry_index %0d, expected %0d",
                got.entry_index, want.entry_index));
        if (got.peer_total !== want.peer_total)
            note_failure($sformatf("peer_total %0d, expected %0d",
                got.peer_total, want.peer_total));
        if (got.closest_signal !== want.closest_signal)
            note_failure($sformatf("closest_signal %0d, expected %0d",
                got.closest_signal, want.closest_signal));
        if (got.newly_gone !== want.newly_gone)
            note_failure($sformatf("newly_gone %0d, expected %0d",
                got.newly_gone, want.newly_gone));
    endtask

    // Watch config writes and both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            accept_version = PROTOCOL_VERSION_RST;
            self_key       = OWN_FINGERPRINT_RST;
            expire_ms      = TIMEOUT_MS_RST;
            fill_level     = '0;
            pending_results.delete();
            open_requests <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_PROTOCOL_VERSION: accept_version = cfg_wr_data[VER_W-1:0];
                    CFG_OWN_FINGERPRINT:  self_key       = cfg_wr_data;
                    CFG_TIMEOUT_MS:       expire_ms      = cfg_wr_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                check_response(m_rsp);
            end
            if (s_valid && s_ready)
                pending_results.push_back(advance_table(s_req));
            open_requests <= pending_results.size();
        end
    end

endmodule

[sim/tb_peer_table_with_aging_unit.sv]
module tb_peer_table_with_aging_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import pta_pkg::*;

    localparam int CLK_HALF_NS   = 2;
    localparam int LATENCY       = MAX_PEERS + 2;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 235;
    localparam int POOL_SIZE     = 20;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam logic [FP_W-1:0]      FP_ALL_ONES   = '1;
    localparam logic signed [SIG_W-1:0] SIG_MIN = 8'sh80;
    localparam logic signed [SIG_W-1:0] SIG_MAX = 8'sh7f;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    in_req_t               s_req        = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    out_rsp_t              m_rsp;
    int                    fail_count;
    int                    open_requests;

    // Stimulus-side view of the settings
    bit                calm          = 1'b0;  // no idle cycles on either side
    logic [VER_W-1:0]  cur_version   = PROTOCOL_VERSION_RST;
    logic [FP_W-1:0]   cur_own       = OWN_FINGERPRINT_RST;
    logic [TIME_W-1:0] clock_ms      = '0;
    int unsigned       time_step_max = 3751;
    logic [FP_W-1:0]   peer_pool [POOL_SIZE];

    peer_table_with_aging_unit DUT (.*);

    pta_table_checker u_checker (.*);

    initial begin
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_peer_table_with_aging_unit failed");
        $finish;
    end

    function automatic int unsigned pick_wait();
        if (calm)
            return 0;
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 15);
            1:       return $urandom_range(0, 3);
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [SIG_W-1:0] rand_signal();
        return ($urandom_range(0, 9) == 0) ? SIG_MIN : SIG_W'($urandom);
    endfunction

    // Well-formed advert at the current time
    function automatic in_req_t advert(input logic [FP_W-1:0] fp,
                                       input logic signed [SIG_W-1:0] sig);
        in_req_t r;
        r.op              = 1'b0;
        r.now_ms          = clock_ms;
        r.payload_short   = 1'b0;
        r.adv_version     = cur_version;
        r.fingerprint     = fp;
        r.run_count       = CTR_W'($urandom);
        r.total_count     = CTR_W'($urandom);
        r.signal_strength = sig;
        return r;
    endfunction

    // Advert with random content, mostly rejected or refused
    function automatic in_req_t noise_item();
        in_req_t r;
        r.op              = 1'b0;
        r.now_ms          = $urandom;
        r.payload_short   = 1'($urandom_range(0, 1));
        r.adv_version     = ($urandom_range(0, 3) == 0) ? cur_version : VER_W'($urandom);
        r.fingerprint     = {$urandom, $urandom};
        r.run_count       = CTR_W'($urandom);
        r.total_count     = CTR_W'($urandom);
        r.signal_strength = rand_signal();
        return r;
    endfunction

    // Check request; the advert fields carry junk
    function automatic in_req_t check_at(input logic [TIME_W-1:0] now);
        in_req_t r;
        r        = noise_item();
        r.op     = 1'b1;
        r.now_ms = now;
        return r;
    endfunction

    function automatic in_req_t random_item();
        in_req_t     r;
        int unsigned pick;
        pick     = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, time_step_max);
        if (pick < 15)
            r = check_at(($urandom_range(0, 19) == 0) ? $urandom : clock_ms);
        else if (pick < 27)
            r = noise_item();
        else if (pick < 32)
            r = advert(cur_own, rand_signal());
        else
            r = advert(peer_pool[$urandom_range(0, POOL_SIZE - 1)], rand_signal());
        // occasional time jump on any advert, noise included (never on a check)
        if (!r.op && $urandom_range(0, 29) == 0)
            r.now_ms = $urandom;
        return r;
    endfunction

    // Drive one request and hold it until accepted
    task automatic send_req(input in_req_t r);
        int unsigned gap;
        gap = pick_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait until every response is back
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (open_requests != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
    endtask

    // Only called with the block idle; junk above the version and timeout register widths
    task automatic set_config(input logic [VER_W-1:0] ver, input logic [FP_W-1:0] own,
                              input logic [TIME_W-1:0] tmo);
        cur_version = ver;
        cur_own     = own;
        if (tmo == 0)
            time_step_max = 2;
        else if (tmo > 32'h1000_0000)
            time_step_max = 32'h1000_0000;
        else
            time_step_max = tmo / 8 + 1;
        write_reg(CFG_SPARE_IDX, {$urandom, $urandom});
        write_reg(CFG_PROTOCOL_VERSION, {32'($urandom), 24'($urandom), ver});
        write_reg(CFG_OWN_FINGERPRINT, own);
        write_reg(CFG_TIMEOUT_MS, {32'($urandom), tmo});
        cfg_wr_en <= 1'b0;
    endtask

    // Response side: random stall before taking each response
    initial begin : receiver
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = pick_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : stimulus
        in_req_t     r;
        int unsigned phase;
        int unsigned n;
        foreach (peer_pool[i])
            peer_pool[i] = {$urandom, $urandom};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: rejections, -128 alone, wrap, aging edge
        clock_ms = 32'hFFFF_FFF0;
        r = advert(peer_pool[0], 8'sd5);
        r.payload_short = 1'b1;
        send_req(r);
        r = advert(peer_pool[0], 8'sd5);
        r.adv_version = 8'd0;
        send_req(r);
        r.adv_version = 8'd255;
        send_req(r);
        send_req(advert('0, 8'sd10));
        send_req(advert(peer_pool[0], SIG_MIN));
        send_req(check_at(clock_ms + 32'h20));
        send_req(advert(FP_ALL_ONES, SIG_MAX));
        send_req(advert(peer_pool[1], -8'sd1));
        r = advert(peer_pool[0], 8'sd0);
        r.run_count   = '1;
        r.total_count = '1;
        send_req(r);
        send_req(check_at(clock_ms + TIMEOUT_MS_RST));
        send_req(check_at(clock_ms + TIMEOUT_MS_RST + 32'd1));
        r = check_at(clock_ms);
        r.payload_short = 1'b1;
        r.adv_version   = 8'd0;
        send_req(r);
        clock_ms = clock_ms + 32'd40000;
        send_req(advert(peer_pool[1], SIG_MAX));
        wait_idle();

        // Top version, all-ones self, zero timeout
        set_config(8'd255, FP_ALL_ONES, 32'd0);
        send_req(advert(FP_ALL_ONES, 8'sd3));
        r = advert(peer_pool[2], 8'sd3);
        r.adv_version = PROTOCOL_VERSION_RST;
        send_req(r);
        send_req(advert(peer_pool[2], 8'sd100));
        send_req(check_at(clock_ms));
        send_req(check_at(clock_ms + 32'd1));
        send_req(advert('0, SIG_MIN));
        wait_idle();

        // Largest timeout: nothing ages out
        set_config(8'd255, FP_ALL_ONES, 32'hFFFF_FFFF);
        send_req(check_at(clock_ms + 32'h8000_0000));
        send_req(advert(peer_pool[3], -8'sd60));
        wait_idle();

        // Random phases, each with its own settings
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_config(8'd1, '0, 32'd100);
                1: set_config(8'd0, FP_ALL_ONES, 32'd0);
                2: set_config(8'd255, peer_pool[POOL_SIZE - 1], 32'd30000);
                3: set_config(VER_W'($urandom), {$urandom, $urandom}, 32'hFFFF_FFFF);
                4: set_config(VER_W'($urandom), {$urandom, $urandom},
                              32'($urandom_range(1, 5000)));
                default: set_config(VER_W'($urandom),
                                    peer_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom);
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_req(random_item());
            end
            wait_idle();
        end

        repeat (2 * LATENCY) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_peer_table_with_aging_unit passed");
        end else begin
            $display("tb_peer_table_with_aging_unit failed");
        end
        $finish;
    end

endmodule
